// ===== design/hb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hb_pkg: shared types and constants of the 2d histogram binner
// Field widths, status and register codes, and the bin count clamp.
// ----------------------------------------------------------------------------
package hb_pkg;

	// field widths
	localparam int SAMPLE_W    = 32;
	localparam int BIN_W       = 5;
	localparam int OUT_BIN_W   = 4;
	localparam int TOTAL_W     = 32;
	localparam int STATUS_W    = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CURSOR_W    = 2 * BIN_W;
	localparam int DIV_NUM_W   = SAMPLE_W + BIN_W;
	localparam int DIV_STEP_W  = $clog2(BIN_W + 1);

	// packed stream widths
	localparam int IN_TDATA_W  = 2 * SAMPLE_W;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 2 * OUT_BIN_W + TOTAL_W;

	// parameter defaults
	localparam int DEF_MAX_X_BINS = 16;
	localparam int DEF_MAX_Y_BINS = 16;
	localparam int DEF_COUNT_BITS = 32;

	// register reset values
	localparam logic [BIN_W-1:0] BINS_RESET = BIN_W'(16);

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_MISSING   = 3'd1,
		STAT_X_OUT     = 3'd2,
		STAT_Y_OUT     = 3'd3,
		STAT_BAD_RANGE = 3'd4
	} status_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_LOW    = 3'd0,
		CFG_X_HIGH   = 3'd1,
		CFG_X_BINS   = 3'd2,
		CFG_Y_LOW    = 3'd3,
		CFG_Y_HIGH   = 3'd4,
		CFG_Y_BINS   = 3'd5
	} cfg_reg_t;

	// bins in use: zero means one, above the store size means the store size
	function automatic logic [BIN_W-1:0] clamp_bins(input logic [BIN_W-1:0] v,
			input int maxb);
		logic [BIN_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = BIN_W'(1);
		end else if (int'(v) > maxb) begin
			r = BIN_W'(maxb);
		end
		return r;
	endfunction

endpackage

// ===== design/histogram_2d_binner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// histogram_2d_binner: uniform 2d histogram with saturating bin counters
// Bins x,y samples over configured ranges and drains bins in order.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request per item: an add of sample (x, y) or a drain of
//   the next bin. m_* returns exactly one result per request: status in
//   m_tuser, bin indexes and count in m_tdata, m_tlast on the final drained
//   bin. cfg_* writes the range and bin count registers; it is always ready
//   and is only to be written while no request is in flight.
//   Flow: the bin index is an exact quotient from one shared 5-step
//   restoring divider, run once per axis for an add and once (cursor over
//   y bins) for a drain, then a read-modify-write of the counter RAM; a
//   skipped sample goes from its checks straight to the result. s_tready
//   rises again in the cycle the result appears on m_*, so a new request
//   is taken only once the previous one is through.
//   Reset: the control and configuration registers return to their reset
//   values and the counter RAM is cleared, one entry per cycle, while
//   s_tready stays low.
//   Stall: the result sits in the output register; the block accepts the
//   next request and runs it, and waits only to load its own result until
//   the previous one has been taken.
// ----------------------------------------------------------------------------
module histogram_2d_binner #(
	parameter int MAX_X_BINS = hb_pkg::DEF_MAX_X_BINS,
	parameter int MAX_Y_BINS = hb_pkg::DEF_MAX_Y_BINS,
	parameter int COUNT_BITS = hb_pkg::DEF_COUNT_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [hb_pkg::IN_TDATA_W-1:0]    s_tdata,  // x_sample, y_sample
	input  logic [hb_pkg::IN_TUSER_W-1:0]    s_tuser,  // mode, x_missing, y_missing
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [hb_pkg::OUT_TDATA_W-1:0]   m_tdata,  // bin_x, bin_y, bin_total
	output logic [hb_pkg::STATUS_W-1:0]      m_tuser,  // status
	output logic                             m_tlast,  // last_bin
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hb_pkg::SAMPLE_W-1:0]      cfg_data
);
	import hb_pkg::*;

	localparam int DEPTH = MAX_X_BINS * MAX_Y_BINS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_CHECK = 8'b0000_0100,
		S_MUL   = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_READ  = 8'b0010_0000,
		S_WRITE = 8'b0100_0000,
		S_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic signed [SAMPLE_W-1:0] x_low_q, x_high_q, y_low_q, y_high_q;
	logic [BIN_W-1:0]           x_bins_q, y_bins_q;

	// request and working registers
	logic                       drain_q, ysel_q, xmiss_q, ymiss_q;
	logic signed [SAMPLE_W-1:0] xs_q, ys_q;
	logic [SAMPLE_W-1:0]        offx_q, offy_q, spanx_q, spany_q;
	logic [BIN_W-1:0]           bx_q, by_q;
	logic [CURSOR_W-1:0]        cursor_q;
	logic [AW-1:0]              clr_q;
	status_t                    status_q;
	logic [TOTAL_W-1:0]         total_q;
	logic                       last_q;

	// output register
	logic                       m_tvalid_q;
	status_t                    out_status_q;
	logic [OUT_BIN_W-1:0]       out_bx_q, out_by_q;
	logic [TOTAL_W-1:0]         out_total_q;
	logic                       out_last_q;

	// combinational
	logic [BIN_W-1:0]           xb, yb, nb_sel;
	logic [CURSOR_W-1:0]        used, cur_fix;
	logic                       bad_range, x_out, y_out, last_c;
	status_t                    chk_status;
	logic [SAMPLE_W-1:0]        span_sel;
	logic [DIV_NUM_W-1:0]       mul_prod, div_num;
	logic [SAMPLE_W-1:0]        div_den, div_rem;
	logic [BIN_W-1:0]           div_quot, bin_res;
	logic                       div_start, div_done;
	logic [AW-1:0]              mem_addr, ram_waddr;
	logic                       ram_we, ram_re;
	logic [COUNT_BITS-1:0]      ram_wdata, ram_rdata, inc_val;

	// configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= '0;
			x_high_q <= '0;
			x_bins_q <= BINS_RESET;
			y_low_q  <= '0;
			y_high_q <= '0;
			y_bins_q <= BINS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_X_LOW:  x_low_q  <= cfg_data;
				CFG_X_HIGH: x_high_q <= cfg_data;
				CFG_X_BINS: x_bins_q <= cfg_data[BIN_W-1:0];
				CFG_Y_LOW:  y_low_q  <= cfg_data;
				CFG_Y_HIGH: y_high_q <= cfg_data;
				CFG_Y_BINS: y_bins_q <= cfg_data[BIN_W-1:0];
				default: ;
			endcase
		end
	end

	// bins in use and drain area
	assign xb      = clamp_bins(x_bins_q, MAX_X_BINS);
	assign yb      = clamp_bins(y_bins_q, MAX_Y_BINS);
	assign used    = CURSOR_W'(xb) * CURSOR_W'(yb);
	assign cur_fix = (cursor_q >= used) ? '0 : cursor_q;
	assign last_c  = (cursor_q == used - 1'b1);

	// sample checks in priority order
	assign bad_range = (x_low_q > x_high_q) || (y_low_q > y_high_q);
	assign x_out     = (xs_q < x_low_q) || (xs_q > x_high_q);
	assign y_out     = (ys_q < y_low_q) || (ys_q > y_high_q);

	always_comb begin
		priority if (bad_range) begin
			chk_status = STAT_BAD_RANGE;
		end else if (xmiss_q || ymiss_q) begin
			chk_status = STAT_MISSING;
		end else if (x_out) begin
			chk_status = STAT_X_OUT;
		end else if (y_out) begin
			chk_status = STAT_Y_OUT;
		end else begin
			chk_status = STAT_OK;
		end
	end

	// scale offset by bin count for the selected axis
	assign nb_sel   = ysel_q ? yb : xb;
	assign span_sel = ysel_q ? spany_q : spanx_q;
	assign mul_prod = DIV_NUM_W'(ysel_q ? offy_q : offx_q) * DIV_NUM_W'(nb_sel);

	// divider operands: scaled offset over span, or drain cursor over y bins
	assign div_start = (state_q == S_MUL) || ((state_q == S_CHECK) && drain_q);
	assign div_num   = (state_q == S_MUL) ? mul_prod : DIV_NUM_W'(cur_fix);
	assign div_den   = drain_q ? SAMPLE_W'(yb) : span_sel;

	hb_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// bin from quotient: zero-width range to bin 0, high bound to last bin
	always_comb begin
		priority if (span_sel == '0) begin
			bin_res = '0;
		end else if (div_quot >= nb_sel) begin
			bin_res = nb_sel - 1'b1;
		end else begin
			bin_res = div_quot;
		end
	end

	// counter store access
	assign mem_addr  = AW'(int'(bx_q) * MAX_Y_BINS + int'(by_q));
	assign inc_val   = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
	assign ram_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : mem_addr;
	assign ram_wdata = ((state_q == S_CLEAR) || drain_q) ? '0 : inc_val;
	assign ram_re    = (state_q == S_READ);

	hb_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (mem_addr),
		.rdata (ram_rdata)
	);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			cursor_q <= '0;
			ysel_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					ysel_q <= 1'b0;
					if (drain_q) begin
						cursor_q <= cur_fix;
						state_q  <= S_DIV;
					end else if (chk_status != STAT_OK) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (drain_q || ysel_q) begin
							state_q <= S_READ;
						end else begin
							ysel_q  <= 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_READ: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (drain_q) begin
						cursor_q <= last_c ? '0 : cursor_q + 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				xs_q    <= s_tdata[SAMPLE_W-1:0];
				ys_q    <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
				drain_q <= s_tuser[0];
				xmiss_q <= s_tuser[1];
				ymiss_q <= s_tuser[2];
			end
			S_CHECK: begin
				status_q <= drain_q ? STAT_OK : chk_status;
				offx_q   <= xs_q - x_low_q;
				offy_q   <= ys_q - y_low_q;
				spanx_q  <= x_high_q - x_low_q;
				spany_q  <= y_high_q - y_low_q;
				bx_q     <= '0;
				by_q     <= '0;
				total_q  <= '0;
				last_q   <= 1'b0;
			end
			S_DIV: begin
				if (div_done) begin
					if (drain_q) begin
						bx_q <= div_quot;
						by_q <= div_rem[BIN_W-1:0];
					end else if (ysel_q) begin
						by_q <= bin_res;
					end else begin
						bx_q <= bin_res;
					end
				end
			end
			S_WRITE: begin
				total_q <= TOTAL_W'(drain_q ? ram_rdata : inc_val);
				last_q  <= drain_q && last_c;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_EMIT) && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_EMIT) && (!m_tvalid_q || m_tready)) begin
			out_status_q <= status_q;
			out_bx_q     <= bx_q[OUT_BIN_W-1:0];
			out_by_q     <= by_q[OUT_BIN_W-1:0];
			out_total_q  <= total_q;
			out_last_q   <= last_q;
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_total_q, out_by_q, out_bx_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	// divider finishes only while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider done outside divide step");

	// counter update stays inside the bins in use
	a_bin_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> ((bx_q < xb) && (by_q < yb)))
		else $error("bin index outside bins in use");

	// drain cursor stays inside the drain area after a drain
	a_cursor_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_WRITE) && drain_q) |=> (cursor_q < used))
		else $error("drain cursor beyond bins in use");

endmodule

// ===== design/hb_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hb_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle, no reset on the array.
// ----------------------------------------------------------------------------
module hb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/hb_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hb_divider: shared restoring divider, one quotient bit per cycle
// Quotient is known to fit BIN_W bits (num >> BIN_W is below den).
// ----------------------------------------------------------------------------
module hb_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [hb_pkg::DIV_NUM_W-1:0]   num,
	input  logic [hb_pkg::SAMPLE_W-1:0]    den,
	output logic                           done,
	output logic [hb_pkg::BIN_W-1:0]       quot,
	output logic [hb_pkg::SAMPLE_W-1:0]    rem
);
	import hb_pkg::*;

	logic [SAMPLE_W-1:0]   rem_q;
	logic [SAMPLE_W-1:0]   den_q;
	logic [BIN_W-1:0]      low_q;
	logic [BIN_W-1:0]      quot_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic                  run_q;
	logic [SAMPLE_W:0]     shifted;
	logic [SAMPLE_W:0]     trial;

	// one trial subtraction per step
	assign shifted = {rem_q, low_q[BIN_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= DIV_STEP_W'(BIN_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (run_q) begin
			run_q <= 1'b0;
		end
	end

	// remainder and quotient datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[DIV_NUM_W-1:BIN_W];
			low_q  <= num[BIN_W-1:0];
			den_q  <= den;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			low_q <= {low_q[BIN_W-2:0], 1'b0};
			if (!trial[SAMPLE_W]) begin
				rem_q  <= trial[SAMPLE_W-1:0];
				quot_q <= {quot_q[BIN_W-2:0], 1'b1};
			end else begin
				rem_q  <= shifted[SAMPLE_W-1:0];
				quot_q <= {quot_q[BIN_W-2:0], 1'b0};
			end
		end
	end

	assign done = run_q && (cnt_q == '0);
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule
